/* rtl/disk_head_position_unit_assert.svh */
// Assertion macros used by the checker file of the disk head position unit.
`ifndef DISK_HEAD_POSITION_UNIT_ASSERT_SVH
`define DISK_HEAD_POSITION_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DHP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("disk head position unit: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("disk head position unit: assertion failed");

`endif

/* rtl/dhp_pkg.sv */
// Package with types and constants of the disk head position unit.
`timescale 1ns / 1ps

package dhp_pkg;

	localparam int MAX_DISKS   = 16;
	localparam int MAX_TRACKS  = 4096;
	localparam int MAX_SECTORS = 256;

	localparam int DIV_W  = 32;
	localparam int DVS_W  = 22;
	localparam int STEP_W = 6;

	localparam logic [1:0] REG_DISK_COUNT   = 2'd0;
	localparam logic [1:0] REG_TRACK_COUNT  = 2'd1;
	localparam logic [1:0] REG_SECTOR_COUNT = 2'd2;
	localparam logic [1:0] REG_SECT_PER_BLK = 2'd3;

	localparam logic [1:0] CMD_SET     = 2'd0;
	localparam logic [1:0] CMD_MOVE    = 2'd1;
	localparam logic [1:0] CMD_ADVANCE = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SET_DISK,
		ST_SET_TRK,
		ST_SET_SEC,
		ST_MV_PT,
		ST_MV_MUL,
		ST_MV_BLK,
		ST_MV_SURF,
		ST_MV_TRK,
		ST_MV_SEC,
		ST_ADV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [4:0]  nd;
		logic [12:0] nt;
		logic [8:0]  ns;
		logic [8:0]  spb;
	} cfg_eff_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
		logic [DIV_W-1:0]  dividend;
		logic [DVS_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [DVS_W-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic        valid;
		logic [3:0]  disk;
		logic        surface;
		logic [11:0] track;
		logic [7:0]  sector;
		logic        oor;
	} res_t;

endpackage

/* rtl/disk_head_position_unit.sv */
// Top level of the disk head position unit: configuration, stream ports and output register.
//
// The unit keeps a disk head position and takes one command per input transaction on the
// s_ channel: s_tuser carries the command, s_tdata the block number and target position.
// Each command yields exactly one transaction on the m_ channel with the position after
// the command and an out-of-range flag. Counts are written through cfg_we, cfg_addr and
// cfg_data; the user must write them only while the unit is idle, the unit does not enforce
// it. A count of zero acts as one, a count above its maximum saturates.
// One input is taken at a time. The shared divider resolves one quotient bit per cycle, so the
// time a command takes follows from the divisions it needs. Advancing a sector needs no
// division, a direct set needs three 16-bit remainders and a block move needs a 9-bit, a
// 32-bit and a 21-bit division plus two products; a block move that ends out of range
// stops after its first or second division. The result reaches m_tvalid in the same cycle
// in which the next transaction can be taken, even if the receiver has not taken it.
// When the receiver stalls, the output register holds its transaction and the sequencer
// waits with the next result until the register is free. Reset clears the position to
// disk 0, surface 0, track 0, sector 0 and sets every count to one.
`timescale 1ns / 1ps

module disk_head_position_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [12:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// block_number[31:0], target_disk[47:32], target_surface[48], target_track[64:49],
	// target_sector[80:65], zero padding[87:81]
	input  logic [87:0] s_tdata,
	// cmd[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// head_disk[3:0], head_surface[4], head_track[16:5], head_sector[24:17],
	// out_of_range[25], zero padding[31:26]
	output logic [31:0] m_tdata
);
	import dhp_pkg::*;

	logic [4:0]  disk_cnt_q;
	logic [12:0] track_cnt_q;
	logic [8:0]  sector_cnt_q;
	logic [8:0]  spb_q;

	cfg_eff_t cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;
	res_t     res;

	logic        idle;
	logic        res_ready;
	logic        m_tvalid_q;
	logic [25:0] m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_cnt_q   <= 5'd1;
			track_cnt_q  <= 13'd1;
			sector_cnt_q <= 9'd1;
			spb_q        <= 9'd1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_DISK_COUNT:   disk_cnt_q   <= cfg_data[4:0];
				REG_TRACK_COUNT:  track_cnt_q  <= cfg_data;
				REG_SECTOR_COUNT: sector_cnt_q <= cfg_data[8:0];
				REG_SECT_PER_BLK: spb_q        <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		priority if (disk_cnt_q == 5'd0) cfg.nd = 5'd1;
		else if (disk_cnt_q > 5'(MAX_DISKS)) cfg.nd = 5'(MAX_DISKS);
		else cfg.nd = disk_cnt_q;

		priority if (track_cnt_q == 13'd0) cfg.nt = 13'd1;
		else if (track_cnt_q > 13'(MAX_TRACKS)) cfg.nt = 13'(MAX_TRACKS);
		else cfg.nt = track_cnt_q;

		priority if (sector_cnt_q == 9'd0) cfg.ns = 9'd1;
		else if (sector_cnt_q > 9'(MAX_SECTORS)) cfg.ns = 9'(MAX_SECTORS);
		else cfg.ns = sector_cnt_q;

		priority if (spb_q == 9'd0) cfg.spb = 9'd1;
		else if (spb_q > 9'(MAX_SECTORS)) cfg.spb = 9'(MAX_SECTORS);
		else cfg.spb = spb_q;
	end

	dhp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	dhp_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.start          (s_tvalid && s_tready),
		.cmd            (s_tuser),
		.block_number   (s_tdata[31:0]),
		.target_disk    (s_tdata[47:32]),
		.target_surface (s_tdata[48]),
		.target_track   (s_tdata[64:49]),
		.target_sector  (s_tdata[80:65]),
		.idle           (idle),
		.res_ready      (res_ready),
		.res            (res),
		.div_req        (div_req),
		.div_rsp        (div_rsp)
	);

	assign s_tready  = idle;
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			m_data_q <= {res.oor, res.sector, res.track, res.surface, res.disk};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, m_data_q};

endmodule

/* rtl/dhp_div.sv */
// Shared restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module dhp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  dhp_pkg::div_req_t req,
	output dhp_pkg::div_rsp_t rsp
);
	import dhp_pkg::*;

	logic [DIV_W-1:0]  q_q;
	logic [DVS_W-1:0]  r_q;
	logic [DVS_W-1:0]  d_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DVS_W:0] sh;
	logic [DVS_W:0] diff;
	logic           ge;

	assign sh   = {r_q, q_q[DIV_W-1]};
	assign diff = sh - {1'b0, d_q};
	assign ge   = (sh >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEP_W'(1);
			if (cnt_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= req.dividend;
			r_q <= '0;
			d_q <= req.divisor;
		end else if (busy_q) begin
			q_q <= {q_q[DIV_W-2:0], ge};
			r_q <= ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = q_q;
	assign rsp.rem  = r_q;

endmodule

/* rtl/dhp_ctrl.sv */
// Command sequencer and head position registers of the disk head position unit.
`timescale 1ns / 1ps

module dhp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  dhp_pkg::cfg_eff_t cfg,
	input  logic              start,
	input  logic [1:0]        cmd,
	input  logic [31:0]       block_number,
	input  logic [15:0]       target_disk,
	input  logic              target_surface,
	input  logic [15:0]       target_track,
	input  logic [15:0]       target_sector,
	output logic              idle,
	input  logic              res_ready,
	output dhp_pkg::res_t     res,
	output dhp_pkg::div_req_t div_req,
	input  dhp_pkg::div_rsp_t div_rsp
);
	import dhp_pkg::*;

	state_t state_q, state_d;

	logic [31:0] blk_q;
	logic [15:0] tdisk_q;
	logic        tsurf_q;
	logic [15:0] ttrk_q;
	logic [15:0] tsec_q;

	logic [3:0]  pos_disk_q;
	logic        pos_surf_q;
	logic [11:0] pos_trk_q;
	logic [7:0]  pos_sec_q;
	logic        oor_q;

	logic [8:0]  pt_q;
	logic [20:0] psurf_q;
	logic [3:0]  mv_disk_q;
	logic        mv_surf_q;
	logic [21:0] rest_q;
	logic [11:0] mv_trk_q;
	logic [7:0]  mv_rem_q;
	logic        issued_q;

	logic        div_state;
	logic [12:0] mul_a;
	logic [8:0]  mul_b;
	logic [21:0] prod;
	logic        blk_oor;

	logic [8:0]  sec_inc;
	logic [12:0] trk_inc;
	logic [4:0]  disk_inc;

	assign sec_inc  = {1'b0, pos_sec_q} + 9'd1;
	assign trk_inc  = {1'b0, pos_trk_q} + 13'd1;
	assign disk_inc = {1'b0, pos_disk_q} + 5'd1;
	assign blk_oor  = (div_rsp.quot >= {27'b0, cfg.nd});

	always_comb begin
		mul_a = cfg.nt;
		mul_b = pt_q;
		if (state_q == ST_MV_SEC) begin
			mul_a = {5'b0, mv_rem_q};
			mul_b = cfg.spb;
		end
	end

	assign prod = 22'(mul_a) * 22'(mul_b);

	always_comb begin
		div_state        = 1'b1;
		div_req.steps    = STEP_W'(16);
		div_req.dividend = {tdisk_q, 16'b0};
		div_req.divisor  = {17'b0, cfg.nd};
		unique case (state_q)
			ST_SET_DISK: begin
			end
			ST_SET_TRK: begin
				div_req.dividend = {ttrk_q, 16'b0};
				div_req.divisor  = {9'b0, cfg.nt};
			end
			ST_SET_SEC: begin
				div_req.dividend = {tsec_q, 16'b0};
				div_req.divisor  = {13'b0, cfg.ns};
			end
			ST_MV_PT: begin
				div_req.steps    = STEP_W'(9);
				div_req.dividend = {cfg.ns, 23'b0};
				div_req.divisor  = {13'b0, cfg.spb};
			end
			ST_MV_BLK: begin
				div_req.steps    = STEP_W'(32);
				div_req.dividend = blk_q;
				div_req.divisor  = {psurf_q, 1'b0};
			end
			ST_MV_TRK: begin
				div_req.steps    = STEP_W'(21);
				div_req.dividend = {rest_q[20:0], 11'b0};
				div_req.divisor  = {13'b0, pt_q};
			end
			default: begin
				div_state = 1'b0;
			end
		endcase
		div_req.start = div_state && !issued_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (cmd)
						CMD_SET:     state_d = ST_SET_DISK;
						CMD_MOVE:    state_d = ST_MV_PT;
						CMD_ADVANCE: state_d = ST_ADV;
						default:     state_d = ST_DONE;
					endcase
				end
			end
			ST_SET_DISK: if (div_rsp.done) state_d = ST_SET_TRK;
			ST_SET_TRK:  if (div_rsp.done) state_d = ST_SET_SEC;
			ST_SET_SEC:  if (div_rsp.done) state_d = ST_DONE;
			ST_MV_PT: begin
				if (div_rsp.done) begin
					state_d = (div_rsp.quot[8:0] == 9'd0) ? ST_DONE : ST_MV_MUL;
				end
			end
			ST_MV_MUL: state_d = ST_MV_BLK;
			ST_MV_BLK: begin
				if (div_rsp.done) begin
					state_d = blk_oor ? ST_DONE : ST_MV_SURF;
				end
			end
			ST_MV_SURF: state_d = ST_MV_TRK;
			ST_MV_TRK:  if (div_rsp.done) state_d = ST_MV_SEC;
			ST_MV_SEC:  state_d = ST_DONE;
			ST_ADV:     state_d = ST_DONE;
			ST_DONE:    if (res_ready) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			issued_q   <= 1'b0;
			oor_q      <= 1'b0;
			pos_disk_q <= '0;
			pos_surf_q <= 1'b0;
			pos_trk_q  <= '0;
			pos_sec_q  <= '0;
		end else begin
			state_q <= state_d;
			if (div_req.start) begin
				issued_q <= 1'b1;
			end else if (div_rsp.done) begin
				issued_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						oor_q <= 1'b0;
					end
				end
				ST_SET_DISK: if (div_rsp.done) pos_disk_q <= div_rsp.rem[3:0];
				ST_SET_TRK:  if (div_rsp.done) pos_trk_q <= div_rsp.rem[11:0];
				ST_SET_SEC: begin
					if (div_rsp.done) begin
						pos_sec_q  <= div_rsp.rem[7:0];
						pos_surf_q <= tsurf_q;
					end
				end
				ST_MV_PT: begin
					if (div_rsp.done && div_rsp.quot[8:0] == 9'd0) begin
						oor_q <= 1'b1;
					end
				end
				ST_MV_BLK: if (div_rsp.done && blk_oor) oor_q <= 1'b1;
				ST_MV_SEC: begin
					pos_disk_q <= mv_disk_q;
					pos_surf_q <= mv_surf_q;
					pos_trk_q  <= mv_trk_q;
					pos_sec_q  <= prod[7:0];
				end
				ST_ADV: begin
					if (sec_inc < cfg.ns) begin
						pos_sec_q <= sec_inc[7:0];
					end else begin
						pos_sec_q <= '0;
						if (trk_inc < cfg.nt) begin
							pos_trk_q <= trk_inc[11:0];
						end else begin
							pos_trk_q  <= '0;
							pos_surf_q <= !pos_surf_q;
							if (pos_surf_q) begin
								pos_disk_q <= (disk_inc < cfg.nd) ? disk_inc[3:0] : 4'd0;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			blk_q   <= block_number;
			tdisk_q <= target_disk;
			tsurf_q <= target_surface;
			ttrk_q  <= target_track;
			tsec_q  <= target_sector;
		end
		if (state_q == ST_MV_PT && div_rsp.done) begin
			pt_q <= div_rsp.quot[8:0];
		end
		if (state_q == ST_MV_MUL) begin
			psurf_q <= prod[20:0];
		end
		if (state_q == ST_MV_BLK && div_rsp.done) begin
			mv_disk_q <= div_rsp.quot[3:0];
			rest_q    <= div_rsp.rem;
			mv_surf_q <= 1'b0;
		end
		if (state_q == ST_MV_SURF && rest_q >= {1'b0, psurf_q}) begin
			mv_surf_q <= 1'b1;
			rest_q    <= rest_q - {1'b0, psurf_q};
		end
		if (state_q == ST_MV_TRK && div_rsp.done) begin
			mv_trk_q <= div_rsp.quot[11:0];
			mv_rem_q <= div_rsp.rem[7:0];
		end
	end

	assign idle        = (state_q == ST_IDLE);
	assign res.valid   = (state_q == ST_DONE);
	assign res.disk    = pos_disk_q;
	assign res.surface = pos_surf_q;
	assign res.track   = pos_trk_q;
	assign res.sector  = pos_sec_q;
	assign res.oor     = oor_q;

endmodule

/* rtl/dhp_checker.sv */
// Port-level checker of the disk head position unit and its bind statement.
`timescale 1ns / 1ps
`include "disk_head_position_unit_assert.svh"

module dhp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	`DHP_ASSERT_NEXT(a_busy_after_take, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`DHP_ASSERT_NEXT(a_out_held, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`DHP_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))
	`DHP_ASSERT_NOW(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[31:26] == 6'b0)

endmodule

bind disk_head_position_unit dhp_checker u_dhp_checker (.*);
